[hw/rtl/v3n_pkg.sv]
package v3n_pkg;

    localparam int COMPONENT_BITS_DEF    = 16;
    localparam int OUT_FRACTION_BITS_DEF = 14;
    localparam int MID_DEPTH             = 2;

    // Width of the exact sum of three squares
    function automatic int sum_width(input int cb);
        return 2 * cb + 2;
    endfunction

    // Width of the search terms: (2q-1)^2 * S and 4 * c^2 * 2^(2F)
    function automatic int term_width(input int cb, input int fb);
        return 2 * fb + 3 + sum_width(cb);
    endfunction

endpackage

[hw/rtl/v3n_fifo.sv]
module v3n_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth and track the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/v3n_front.sv]
module v3n_front #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [COMPONENT_BITS-1:0] x_in,
    input  logic signed [COMPONENT_BITS-1:0] y_in,
    input  logic signed [COMPONENT_BITS-1:0] z_in,
    output logic                             mid_wr,
    output logic [3+3*2*COMPONENT_BITS+v3n_pkg::sum_width(COMPONENT_BITS)-1:0] mid_data,
    input  logic                             mid_full
);
    import v3n_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int SQ = 2 * CB;
    localparam int SW = sum_width(CB);

    logic          v_reg;
    logic [2:0]    neg_reg, neg_next;
    logic [SQ-1:0] sq_reg [0:2];
    logic [SQ-1:0] sq_next [0:2];
    logic [SW-1:0] s_reg, s_next;
    logic [CB-1:0] comp [0:2];
    logic [CB-1:0] mag  [0:2];
    logic          ready, take;

    assign ready  = !v_reg || !mid_full;
    assign full   = !ready;
    assign take   = push && ready;
    assign mid_wr = v_reg;

    assign comp[0] = x_in;
    assign comp[1] = y_in;
    assign comp[2] = z_in;

    // Classify: split sign and magnitude, square, sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = comp[i][CB-1];
            mag[i]      = comp[i][CB-1] ? (~comp[i] + 1'b1) : comp[i];
            sq_next[i]  = SQ'(mag[i]) * SQ'(mag[i]);
        end
        s_next = SW'(sq_next[0]) + SW'(sq_next[1]) + SW'(sq_next[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready)
        begin
            v_reg <= push;
        end
    end

    // Hold the classified item until the queue takes it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            neg_reg <= neg_next;
            sq_reg  <= sq_next;
            s_reg   <= s_next;
        end
    end

    assign mid_data = {neg_reg, sq_reg[0], sq_reg[1], sq_reg[2], s_reg};

endmodule

[hw/rtl/v3n_back.sv]
module v3n_back #(
    parameter int COMPONENT_BITS    = 16,
    parameter int OUT_FRACTION_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [3+3*2*COMPONENT_BITS+v3n_pkg::sum_width(COMPONENT_BITS)-1:0] in_data,
    output logic                           out_valid,
    output logic [3*(OUT_FRACTION_BITS+2):0] out_data
);
    import v3n_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int F  = OUT_FRACTION_BITS;
    localparam int SQ = 2 * CB;
    localparam int SW = sum_width(CB);
    localparam int TW = term_width(CB, F);
    localparam int OW = F + 2;

    // Unpacked input item
    logic [2:0]    in_neg;
    logic [SQ-1:0] in_sq [0:2];
    logic [SW-1:0] in_s;

    assign {in_neg, in_sq[0], in_sq[1], in_sq[2], in_s} = in_data;

    // One stage per result bit, most significant first
    logic          v_reg    [0:F];
    logic [2:0]    neg_reg  [0:F];
    logic          zero_reg [0:F];
    logic [SW-1:0] s_reg    [0:F];
    logic [TW-1:0] a_reg    [0:F][0:2];
    logic [TW-1:0] b_reg    [0:F][0:2];
    logic [TW-1:0] r_reg    [0:F][0:2];
    logic [F:0]    q_reg    [0:F][0:2];

    for (genvar j = 0; j <= F; j++)
    begin : g_stage
        localparam int K = F - j;

        logic          v_prev;
        logic [2:0]    neg_prev;
        logic          zero_prev;
        logic [SW-1:0] s_prev;
        logic [TW-1:0] a_prev [0:2];
        logic [TW-1:0] b_prev [0:2];
        logic [TW-1:0] r_prev [0:2];
        logic [F:0]    q_prev [0:2];
        logic [TW-1:0] a_next [0:2];
        logic [TW-1:0] b_next [0:2];
        logic [F:0]    q_next [0:2];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                v_prev    = in_valid;
                neg_prev  = in_neg;
                zero_prev = (in_s == '0);
                s_prev    = in_s;
                for (int i = 0; i < 3; i++)
                begin
                    a_prev[i] = '0;
                    b_prev[i] = '0;
                    q_prev[i] = '0;
                    r_prev[i] = TW'(in_sq[i]) << (2 * F + 2);
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                v_prev    = v_reg[j-1];
                neg_prev  = neg_reg[j-1];
                zero_prev = zero_reg[j-1];
                s_prev    = s_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    a_prev[i] = a_reg[j-1][i];
                    b_prev[i] = b_reg[j-1][i];
                    q_prev[i] = q_reg[j-1][i];
                    r_prev[i] = r_reg[j-1][i];
                end
            end
        end

        // Try bit K: keep it when (2c-1)^2 * S <= R and bit F is not yet set, with A = q^2 S and B = q S
        always_comb
        begin
            logic [TW-1:0] a_try;
            logic [TW-1:0] b_try;
            logic [TW-1:0] test;
            logic          allow;
            for (int i = 0; i < 3; i++)
            begin
                a_try = a_prev[i] + (b_prev[i] << (K + 1)) + (TW'(s_prev) << (2 * K));
                b_try = b_prev[i] + (TW'(s_prev) << K);
                test  = (a_try << 2) - (b_try << 2) + TW'(s_prev);
                allow = (K == F) ? 1'b1 : !q_prev[i][F];
                if (allow && (test <= r_prev[i]))
                begin
                    a_next[i] = a_try;
                    b_next[i] = b_try;
                    q_next[i] = q_prev[i] | ((F+1)'(1) << K);
                end
                else
                begin
                    a_next[i] = a_prev[i];
                    b_next[i] = b_prev[i];
                    q_next[i] = q_prev[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_prev;
            end
        end

        // Advance the item one bit
        always_ff @(posedge clk)
        begin
            neg_reg[j]  <= neg_prev;
            zero_reg[j] <= zero_prev;
            s_reg[j]    <= s_prev;
            for (int i = 0; i < 3; i++)
            begin
                a_reg[j][i] <= a_next[i];
                b_reg[j][i] <= b_next[i];
                r_reg[j][i] <= r_prev[i];
                q_reg[j][i] <= q_next[i];
            end
        end
    end

    // Apply sign, force zero vector
    logic [OW-1:0] res [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg[F])
            begin
                res[i] = '0;
            end
            else if (neg_reg[F][i])
            begin
                res[i] = '0 - OW'(q_reg[F][i]);
            end
            else
            begin
                res[i] = OW'(q_reg[F][i]);
            end
        end
    end

    assign out_valid = v_reg[F];
    assign out_data  = {res[0], res[1], res[2], zero_reg[F]};

endmodule

[hw/rtl/vector3_normalize_unit.sv]
// Vector normalizer: scales (x, y, z) to a signed Q1.F unit vector.
// Input side is a queue: drive x_in/y_in/z_in with push; an item is taken on a
// clock edge with push high and full low. Result side is a queue: while empty
// is low, x_out/y_out/z_out/zero_length show the oldest result; pop takes it.
// Each output is round(c * 2^F / sqrt(x^2+y^2+z^2)), ties away from zero,
// clamped to +-2^F; an all-zero input gives zeros with zero_length set.
// Path from accept to empty low: the accept edge loads the classify stage,
// then one queue slot, one stage per result bit in the bit-serial search
// pipeline, one result queue write.
// Throughput: one item per cycle while the receiver keeps up; each search
// stage takes a new item every cycle. The result queue has room for every
// item in the search pipeline, so a stalled receiver stops new items entering
// the back end, then fills the small middle queue, then raises full. No item
// is ever dropped. Reset clears all queues, valid flags and the credit count.
module vector3_normalize_unit #(
    parameter int COMPONENT_BITS    = v3n_pkg::COMPONENT_BITS_DEF,
    parameter int OUT_FRACTION_BITS = v3n_pkg::OUT_FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [COMPONENT_BITS-1:0]    x_in,
    input  logic signed [COMPONENT_BITS-1:0]    y_in,
    input  logic signed [COMPONENT_BITS-1:0]    z_in,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [OUT_FRACTION_BITS+1:0] x_out,
    output logic signed [OUT_FRACTION_BITS+1:0] y_out,
    output logic signed [OUT_FRACTION_BITS+1:0] z_out,
    output logic                                zero_length
);
    import v3n_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int F      = OUT_FRACTION_BITS;
    localparam int OW     = F + 2;
    localparam int MW     = 3 + 3 * 2 * CB + sum_width(CB);
    localparam int RW     = 3 * OW + 1;
    localparam int ODEPTH = F + 3;
    localparam int KW     = $clog2(ODEPTH + 1);

    logic          mid_wr, mid_full, mid_rd, mid_empty;
    logic [MW-1:0] mid_wdata, mid_rdata;
    logic          res_valid, res_full, out_take;
    logic [RW-1:0] res_data, out_data;
    logic [KW-1:0] credit_reg, credit_next;

    v3n_front #(
        .COMPONENT_BITS(CB)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .x_in     (x_in),
        .y_in     (y_in),
        .z_in     (z_in),
        .mid_wr   (mid_wr),
        .mid_data (mid_wdata),
        .mid_full (mid_full)
    );

    v3n_fifo #(
        .W     (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wdata),
        .full    (mid_full),
        .rd_en   (mid_rd),
        .rd_data (mid_rdata),
        .empty   (mid_empty)
    );

    // Admit an item only when the result queue has a slot reserved for it
    assign mid_rd   = !mid_empty && (credit_reg < KW'(ODEPTH));
    assign out_take = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg;
        if (mid_rd && !out_take)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_take && !mid_rd)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    v3n_back #(
        .COMPONENT_BITS    (CB),
        .OUT_FRACTION_BITS (F)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_rd),
        .in_data   (mid_rdata),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    v3n_fifo #(
        .W     (RW),
        .DEPTH (ODEPTH)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

    assign {x_out, y_out, z_out, zero_length} = out_data;

    // Reserved slots never exceed the result queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= KW'(ODEPTH))
        else $error("credit count above result queue depth");

    // A finished item always finds room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_full)
        else $error("result written into full queue");

    // Zero vector results carry zero components
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_length) |-> (x_out == '0 && y_out == '0 && z_out == '0))
        else $error("zero_length result with nonzero component");

    // No reserved slot means the result side is empty
    a_credit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (credit_reg == '0) |-> empty)
        else $error("result present without reserved slot");

endmodule

[dv/vector3_normalize_checker.sv]
module vector3_normalize_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic signed [15:0] z_in,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [15:0] x_out,
    input  logic signed [15:0] y_out,
    input  logic signed [15:0] z_out,
    input  logic               zero_length,
    output int                 fail_count,
    output int                 pending_count
);
    localparam int FB = 14;

    typedef struct packed {
        logic signed [15:0] xn;
        logic signed [15:0] yn;
        logic signed [15:0] zn;
        logic               zl;
    } unit_vec_t;

    unit_vec_t unit_q[$];

    // Largest q in 0..2^F with (2q-1)^2 * S <= 4 * c^2 * 2^(2F)
    function automatic logic [15:0] round_scaled(input logic [16:0] mag,
                                                 input logic [33:0] sum_sq);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  q;
        rhs = (128'(mag) * 128'(mag)) << (2 * FB + 2);
        lo = 0;
        hi = 32'd1 << FB;
        while (lo < hi)
        begin
            q = lo + (hi - lo + 1) / 2;
            lhs = 128'(2 * q - 1) * 128'(2 * q - 1) * 128'(sum_sq);
            if (lhs <= rhs)
                lo = q;
            else
                hi = q - 1;
        end
        return lo[15:0];
    endfunction

    function automatic unit_vec_t normalize_vec(input logic signed [15:0] xv,
                                                input logic signed [15:0] yv,
                                                input logic signed [15:0] zv);
        unit_vec_t  r;
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        logic [33:0] s;
        logic [15:0] q;
        mx = xv < 0 ? 17'(-32'(xv)) : 17'(xv);
        my = yv < 0 ? 17'(-32'(yv)) : 17'(yv);
        mz = zv < 0 ? 17'(-32'(zv)) : 17'(zv);
        s = 34'(mx) * mx + 34'(my) * my + 34'(mz) * mz;
        r = '0;
        if (s == 0)
        begin
            r.zl = 1'b1;
            return r;
        end
        q = round_scaled(mx, s);
        r.xn = xv < 0 ? -q : q;
        q = round_scaled(my, s);
        r.yn = yv < 0 ? -q : q;
        q = round_scaled(mz, s);
        r.zn = zv < 0 ? -q : q;
        return r;
    endfunction

    assign pending_count = unit_q.size();

    // Predict on accepted input items, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        unit_vec_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (push && !full)
                unit_q.push_back(normalize_vec(x_in, y_in, z_in));
            if (pop && !empty)
            begin
                if (unit_q.size() == 0)
                begin
                    $display("%0t: unexpected item x=%0d y=%0d z=%0d zl=%0b", $time,
                             x_out, y_out, z_out, zero_length);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = unit_q.pop_front();
                    if (e.xn !== x_out || e.yn !== y_out || e.zn !== z_out
                        || e.zl !== zero_length)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d zl=%0b",
                                 $time, e.xn, e.yn, e.zn, e.zl);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d zl=%0b",
                                 $time, x_out, y_out, z_out, zero_length);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[dv/vector3_normalize_unit_test.sv]
module vector3_normalize_unit_test;
    localparam int N_RANDOM = 1900;
    localparam int STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] z_in;
    logic               empty;
    logic               pop;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic signed [15:0] z_out;
    logic               zero_length;
    int                 fail_count;
    int                 pending_count;
    int                 idle_pct_tx;
    int                 idle_pct_rx;
    int                 hold_rx;
    int                 quiet_cycles;

    vector3_normalize_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .empty(empty), .pop(pop),
        .x_out(x_out), .y_out(y_out), .z_out(z_out), .zero_length(zero_length)
    );

    vector3_normalize_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .empty(empty), .pop(pop),
        .x_out(x_out), .y_out(y_out), .z_out(z_out), .zero_length(zero_length),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        x_in = '0;
        y_in = '0;
        z_in = '0;
        idle_pct_tx = 35;
        idle_pct_rx = 35;
        hold_rx = 0;
    end

    // Pick a component: extremes, zero and small values often, otherwise any value
    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item with random idling; return once accepted, push left high
    task automatic send_vec(input logic [15:0] xv, input logic [15:0] yv,
                            input logic [15:0] zv);
        while ($urandom_range(0, 99) < idle_pct_tx)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        x_in <= xv;
        y_in <= yv;
        z_in <= zv;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Receiver: random idling, plus long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_rx > 0)
        begin
            pop <= 1'b0;
            hold_rx <= hold_rx - 1;
        end
        else
            pop <= ($urandom_range(0, 99) >= idle_pct_rx);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("vector3_normalize_unit_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, single axes, extremes, ties region
        send_vec(16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h8000, 16'h0000, 16'h0000);
        send_vec(16'h0000, 16'h7fff, 16'h0000);
        send_vec(16'h0000, 16'h0000, 16'h8000);
        send_vec(16'h0001, 16'h0000, 16'h0000);
        send_vec(16'hffff, 16'h0000, 16'h0000);
        send_vec(16'h8000, 16'h8000, 16'h8000);
        send_vec(16'h7fff, 16'h7fff, 16'h7fff);
        send_vec(16'h8000, 16'h7fff, 16'h8000);
        send_vec(16'h0001, 16'h0001, 16'h0001);
        send_vec(16'hffff, 16'h0001, 16'hffff);
        send_vec(16'h0003, 16'h0004, 16'h0000);
        send_vec(16'hfffd, 16'h0000, 16'hfffc);
        send_vec(16'h0001, 16'h7fff, 16'h8000);
        send_vec(16'h0002, 16'h0001, 16'h0002);
        send_vec(16'h5555, 16'haaaa, 16'h5555);

        // Fill the block: receiver holds off while items keep coming
        hold_rx <= 400;
        for (k = 0; k < 60; k++)
            send_vec(pick_comp(), pick_comp(), pick_comp());
        push <= 1'b0;

        // Sender pauses until every result has come
        while (pending_count != 0)
            @(posedge clk);

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == 600)
            begin
                idle_pct_tx = 0;
                idle_pct_rx = 0;
            end
            if (i == 900)
            begin
                idle_pct_tx = 35;
                idle_pct_rx = 35;
            end
            send_vec(pick_comp(), pick_comp(), pick_comp());
        end
        push <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0 && empty)
            $display("vector3_normalize_unit_test: PASS");
        else
            $display("vector3_normalize_unit_test: FAIL");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_fifo.sv
hw/rtl/v3n_front.sv
hw/rtl/v3n_back.sv
hw/rtl/vector3_normalize_unit.sv
dv/vector3_normalize_checker.sv
dv/vector3_normalize_unit_test.sv
